/* rtl/ide_pkg.sv */
package ide_pkg;

    // Fixed field widths of the command and response items.
    localparam int HANDLE_W = 32;
    localparam int POS_W    = 7;
    localparam int CNT_W    = 7;

    // Command codes.
    localparam logic [3:0] CMD_PUSH_HEAD   = 4'd0;
    localparam logic [3:0] CMD_PUSH_TAIL   = 4'd1;
    localparam logic [3:0] CMD_INSERT_AT   = 4'd2;
    localparam logic [3:0] CMD_PEEK_HEAD   = 4'd3;
    localparam logic [3:0] CMD_PEEK_TAIL   = 4'd4;
    localparam logic [3:0] CMD_PEEK_AT     = 4'd5;
    localparam logic [3:0] CMD_POP_HEAD    = 4'd6;
    localparam logic [3:0] CMD_POP_TAIL    = 4'd7;
    localparam logic [3:0] CMD_POP_AT      = 4'd8;
    localparam logic [3:0] CMD_REMOVE_HEAD = 4'd9;
    localparam logic [3:0] CMD_REMOVE_TAIL = 4'd10;
    localparam logic [3:0] CMD_REMOVE_AT   = 4'd11;
    localparam logic [3:0] CMD_CLEAR       = 4'd12;

    // Status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NULL  = 3'd1;
    localparam logic [2:0] ST_OOB   = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    typedef struct packed {
        logic [3:0]          cmd;
        logic [HANDLE_W-1:0] data_handle;
        logic [POS_W-1:0]    position;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [HANDLE_W-1:0] data_out;
        logic [CNT_W-1:0]    entry_count;
    } rsp_item_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_LOAD,
        CELL_SHIFT
    } cell_op_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SHIFT,
        S_FINISH
    } state_t;

endpackage

/* rtl/ide_cell.sv */
module ide_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 6,
    parameter int DW    = 32
) (
    input  logic              clk,
    input  ide_pkg::cell_op_t op,
    input  logic [IW-1:0]     k,
    input  logic [DW-1:0]     wdata,
    input  logic [DW-1:0]     left_data,
    input  logic [DW-1:0]     right_data,
    input  logic [DW-1:0]     right_rd,
    output logic [DW-1:0]     data,
    output logic [DW-1:0]     rd
);
    import ide_pkg::*;

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic [DW-1:0] rd_reg;
    logic [DW-1:0] rd_next;
    logic          at_k;
    logic          after_k;

    assign at_k    = (IW'(INDEX) == k);
    assign after_k = (IW'(INDEX) > k);

    // Entry update: insert shifts toward the tail, remove shifts toward the head,
    // and the read line carries entries toward cell zero one step per cycle.
    always_comb
    begin
        data_next = data_reg;
        rd_next   = rd_reg;
        unique case (op)
            CELL_HOLD:
            begin
            end
            CELL_INSERT:
            begin
                if (at_k)
                begin
                    data_next = wdata;
                end
                else if (after_k)
                begin
                    data_next = left_data;
                end
            end
            CELL_REMOVE:
            begin
                if (at_k || after_k)
                begin
                    data_next = right_data;
                end
            end
            CELL_LOAD:
            begin
                rd_next = data_reg;
            end
            CELL_SHIFT:
            begin
                rd_next = right_rd;
            end
            default:
            begin
            end
        endcase
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data = data_reg;
    assign rd   = rd_reg;

endmodule

/* rtl/ide_ctrl.sv */
module ide_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  ide_pkg::cmd_item_t    cmd_item,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output ide_pkg::rsp_item_t    rsp_item,
    output ide_pkg::cell_op_t     op,
    output logic [IW-1:0]         k,
    output logic [DATA_WIDTH-1:0] wdata,
    input  logic [DATA_WIDTH-1:0] rd0
);
    import ide_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;
    localparam int PW = (DATA_WIDTH > HANDLE_W) ? DATA_WIDTH : HANDLE_W;

    state_t              state_reg;
    state_t              state_next;
    logic [CW-1:0]       count_reg;
    logic                rsp_valid_reg;
    rsp_item_t           rsp_item_reg;

    logic [2:0]          status_reg;
    logic                read_reg;
    cell_op_t            fin_op_reg;
    logic [IW-1:0]       k_reg;
    logic [IW-1:0]       sh_reg;
    logic [CW-1:0]       cnt_after_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;

    logic                accept;
    logic                commit;

    // Decode of the incoming command.
    logic [PW-1:0]         d_wide;
    logic [DATA_WIDTH-1:0] d_val;
    logic                  pos_bad;
    logic                  grp_access;
    logic                  at_pos;
    logic                  at_tail;
    logic                  want_read;
    logic                  want_remove;
    logic [2:0]            acc_status;
    logic                  acc_read;
    cell_op_t              acc_op;
    logic [IW-1:0]         acc_k;
    logic [CW-1:0]         acc_cnt;

    logic [PW-1:0]         rd_wide;

    assign accept = cmd_valid && cmd_ready;
    assign commit = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);

    assign d_wide  = PW'(cmd_item.data_handle);
    assign d_val   = d_wide[DATA_WIDTH-1:0];
    assign pos_bad = (cmd_item.position == '0) ||
                     (MW'(cmd_item.position) > MW'(count_reg));

    // Checks and target index for the command at the input.
    always_comb
    begin
        acc_status  = ST_OK;
        acc_read    = 1'b0;
        acc_op      = CELL_HOLD;
        acc_k       = '0;
        acc_cnt     = count_reg;
        grp_access  = 1'b0;
        at_pos      = 1'b0;
        at_tail     = 1'b0;
        want_read   = 1'b0;
        want_remove = 1'b0;
        unique case (cmd_item.cmd)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_INSERT_AT:
            begin
                if (d_val == '0)
                begin
                    acc_status = ST_NULL;
                end
                else if ((cmd_item.cmd == CMD_INSERT_AT) && pos_bad)
                begin
                    acc_status = ST_OOB;
                end
                else if (count_reg >= CW'(CAPACITY))
                begin
                    acc_status = ST_FULL;
                end
                else
                begin
                    acc_op  = CELL_INSERT;
                    acc_cnt = count_reg + 1'b1;
                    if (cmd_item.cmd == CMD_PUSH_TAIL)
                    begin
                        acc_k = IW'(count_reg);
                    end
                    else if (cmd_item.cmd == CMD_INSERT_AT)
                    begin
                        acc_k = IW'(cmd_item.position - 1'b1);
                    end
                end
            end
            CMD_PEEK_HEAD:
            begin
                grp_access = 1'b1;
                want_read  = 1'b1;
            end
            CMD_PEEK_TAIL:
            begin
                grp_access = 1'b1;
                want_read  = 1'b1;
                at_tail    = 1'b1;
            end
            CMD_PEEK_AT:
            begin
                grp_access = 1'b1;
                want_read  = 1'b1;
                at_pos     = 1'b1;
            end
            CMD_POP_HEAD:
            begin
                grp_access  = 1'b1;
                want_read   = 1'b1;
                want_remove = 1'b1;
            end
            CMD_POP_TAIL:
            begin
                grp_access  = 1'b1;
                want_read   = 1'b1;
                want_remove = 1'b1;
                at_tail     = 1'b1;
            end
            CMD_POP_AT:
            begin
                grp_access  = 1'b1;
                want_read   = 1'b1;
                want_remove = 1'b1;
                at_pos      = 1'b1;
            end
            CMD_REMOVE_HEAD:
            begin
                grp_access  = 1'b1;
                want_remove = 1'b1;
            end
            CMD_REMOVE_TAIL:
            begin
                grp_access  = 1'b1;
                want_remove = 1'b1;
                at_tail     = 1'b1;
            end
            CMD_REMOVE_AT:
            begin
                grp_access  = 1'b1;
                want_remove = 1'b1;
                at_pos      = 1'b1;
            end
            CMD_CLEAR:
            begin
                acc_cnt = '0;
            end
            default:
            begin
            end
        endcase

        // Peek, pop and remove share the empty and position checks.
        if (grp_access)
        begin
            if (count_reg == '0)
            begin
                acc_status = ST_EMPTY;
            end
            else if (at_pos && pos_bad)
            begin
                acc_status = ST_OOB;
            end
            else
            begin
                acc_read = want_read;
                if (want_remove)
                begin
                    acc_op  = CELL_REMOVE;
                    acc_cnt = count_reg - 1'b1;
                end
                if (at_tail)
                begin
                    acc_k = IW'(count_reg - 1'b1);
                end
                else if (at_pos)
                begin
                    acc_k = IW'(cmd_item.position - 1'b1);
                end
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = acc_read ? S_LOAD : S_FINISH;
                end
            end
            S_LOAD:
            begin
                state_next = (k_reg == '0) ? S_FINISH : S_SHIFT;
            end
            S_SHIFT:
            begin
                if (sh_reg == IW'(1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs toward the cell chain.
    always_comb
    begin
        op = CELL_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_LOAD:
            begin
                op = CELL_LOAD;
            end
            S_SHIFT:
            begin
                op = CELL_SHIFT;
            end
            S_FINISH:
            begin
                if (commit)
                begin
                    op = fin_op_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign k         = k_reg;
    assign wdata     = wdata_reg;
    assign rd_wide   = PW'(rd0);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= cnt_after_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Command context and response payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= acc_status;
            read_reg      <= acc_read;
            fin_op_reg    <= acc_op;
            k_reg         <= acc_k;
            sh_reg        <= acc_k;
            cnt_after_reg <= acc_cnt;
            wdata_reg     <= d_val;
        end
        else if (state_reg == S_SHIFT)
        begin
            sh_reg <= sh_reg - 1'b1;
        end
        if (commit)
        begin
            rsp_item_reg.status      <= status_reg;
            rsp_item_reg.data_out    <= read_reg ? rd_wide[HANDLE_W-1:0] : '0;
            rsp_item_reg.entry_count <= CNT_W'(cnt_after_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

/* rtl/indexed_deque_list_engine.sv */
// A push, insert, remove, clear or failed command goes from idle straight to the finish
// state; a peek or pop first loads the read line, then shifts it until entry k reaches
// cell zero, where k is position - 1 (0 at the head, count - 1 at the tail). The response
// register is loaded in the finish state. One command at a time; the next transfers the
// cycle after the response register is loaded, and the finish state waits while a
// previous response is still held on the response side.
// Reset clears the controller and the response valid, leaving the list empty; cell
// contents are not reset and are never read before they are written.
module indexed_deque_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ide_pkg::cmd_item_t cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ide_pkg::rsp_item_t rsp_item
);
    import ide_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    cell_op_t              op;
    logic [IW-1:0]         k;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [DATA_WIDTH-1:0] left_data [CAPACITY];
    logic [DATA_WIDTH-1:0] right_data[CAPACITY];
    logic [DATA_WIDTH-1:0] right_rd  [CAPACITY];

    // Command decode, walk sequencing and response register.
    ide_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .op        (op),
        .k         (k),
        .wdata     (wdata),
        .rd0       (cell_rd[0])
    );

    // Row of entry cells, cell zero at the head of the list.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_data[i] = wdata;
        end
        else
        begin : g_inner_left
            assign left_data[i] = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data[i] = '0;
            assign right_rd[i]   = '0;
        end
        else
        begin : g_inner_right
            assign right_data[i] = cell_data[i+1];
            assign right_rd[i]   = cell_rd[i+1];
        end

        ide_cell #(
            .INDEX (i),
            .IW    (IW),
            .DW    (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .k          (k),
            .wdata      (wdata),
            .left_data  (left_data[i]),
            .right_data (right_data[i]),
            .right_rd   (right_rd[i]),
            .data       (cell_data[i]),
            .rd         (cell_rd[i])
        );
    end

endmodule
